### src/skla_pkg.sv
package skla_pkg;

   localparam int SEM_ENTRIES = 64;
   localparam int PROCESSES   = 64;

   localparam int IDX_W     = (SEM_ENTRIES > 1) ? $clog2(SEM_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(PROCESSES + 1);
   localparam int KEY_W     = 32;
   localparam int PROC_IN_W = 6;
   localparam int ID_W      = 6;
   localparam int COUNT_W   = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   // search token travelling down the cell chain
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             match_found;
      logic [IDX_W-1:0] match_idx;
      logic [CNT_W-1:0] match_users;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
   } search_token_type;

   // write-back command broadcast to all cells
   typedef struct packed {
      logic                 valid;
      logic                 create;
      logic [IDX_W-1:0]     idx;
      logic [KEY_W-1:0]     key;
      logic [CNT_W-1:0]     users;
      logic                 proc_ok;
      logic [PROC_IN_W-1:0] proc;
   } write_cmd_type;

endpackage

### src/skla_cell.sv
module skla_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [skla_pkg::IDX_W-1:0]     cell_index,
   input  skla_pkg::search_token_type     left_token,
   output skla_pkg::search_token_type     right_token,
   input  skla_pkg::write_cmd_type        wr_cmd
);
   import skla_pkg::*;

   logic                  active_ff, active_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CNT_W-1:0]      users_ff, users_in;
   logic [PROCESSES-1:0]  member_ff, member_in;
   search_token_type      slot_ff, slot_in;
   logic                  wr_hit;

   // examine this entry as the token passes
   always_comb begin
      slot_in = left_token;
      if (left_token.valid) begin
         if (active_ff && (key_ff == left_token.key) && !left_token.match_found) begin
            slot_in.match_found = 1'b1;
            slot_in.match_idx   = cell_index;
            slot_in.match_users = users_ff;
         end
         if (!active_ff && !left_token.free_found) begin
            slot_in.free_found = 1'b1;
            slot_in.free_idx   = cell_index;
         end
      end
   end

   assign wr_hit = wr_cmd.valid && (wr_cmd.idx == cell_index);

   always_comb begin
      active_in = active_ff | (wr_hit & wr_cmd.create);
      key_in    = (wr_hit && wr_cmd.create) ? wr_cmd.key : key_ff;
      users_in  = wr_hit ? wr_cmd.users : users_ff;
      for (int p = 0; p < PROCESSES; p++) begin
         member_in[p] = member_ff[p] |
                        (wr_hit && wr_cmd.proc_ok && (int'(wr_cmd.proc) == p));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         member_ff     <= '0;
         slot_ff.valid <= 1'b0;
      end else begin
         active_ff     <= active_in;
         member_ff     <= member_in;
         slot_ff.valid <= slot_in.valid;
      end
      key_ff              <= key_in;
      users_ff            <= users_in;
      slot_ff.key         <= slot_in.key;
      slot_ff.match_found <= slot_in.match_found;
      slot_ff.match_idx   <= slot_in.match_idx;
      slot_ff.match_users <= slot_in.match_users;
      slot_ff.free_found  <= slot_in.free_found;
      slot_ff.free_idx    <= slot_in.free_idx;
   end

   assign right_token = slot_ff;

endmodule

### src/semaphore_key_lookup_or_allocate_unit.sv
// Semaphore key table: find the active entry holding a key, or claim the
// lowest free entry for it, then record the calling process as a user.
//
// Request channel (req_valid/req_ready): one transaction carries a process
// number and a 32-bit key. Response channel (rsp_valid/rsp_ready): one
// transaction per request with the entry id, a table-full flag, a
// newly-created flag and the entry's user count after the request.
//
// The table lives in a chain of SEM_ENTRIES cells. A search token enters
// cell 0 and advances one cell per cycle, picking up the lowest matching
// entry and the lowest free entry on the way. After it leaves the last cell
// it is captured in the result register. The write-back step then updates
// the selected cell and loads the response. The token passes through every
// cell register into the result register before write-back. One request is
// in flight at a time. The next one is taken in the idle state after
// write-back, so a new request is not taken before the last one is through
// the chain and its write-back.
//
// Reset (synchronous, active high) marks every entry inactive and clears
// all membership bits; no clearing pass is needed. A stalled response
// holds in its output register; the next request is still taken and
// searched, and its write-back waits until the held response is taken.
module semaphore_key_lookup_or_allocate_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [skla_pkg::PROC_IN_W-1:0]    req_process_index,
   input  logic [skla_pkg::KEY_W-1:0]        req_sem_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [skla_pkg::ID_W-1:0]         rsp_semaphore_id,
   output logic                              rsp_table_full,
   output logic                              rsp_newly_created,
   output logic [skla_pkg::COUNT_W-1:0]      rsp_user_count
);
   import skla_pkg::*;

   state_type             state_ff, state_in;
   logic [PROC_IN_W-1:0]  proc_ff;
   search_token_type      result_ff;
   search_token_type      chain [SEM_ENTRIES+1];
   write_cmd_type         wr_cmd;

   logic                  req_take;
   logic                  do_update;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic                  rsp_full_ff;
   logic                  rsp_created_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  created;
   logic                  full;
   logic [IDX_W-1:0]      sel_idx;
   logic [CNT_W-1:0]      base_users;
   logic [CNT_W-1:0]      new_users;

   // ---- control: next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SEARCH;
         ST_SEARCH: if (chain[SEM_ENTRIES].valid) state_in = ST_UPDATE;
         ST_UPDATE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---- control: outputs ----
   always_comb begin
      req_ready = 1'b0;
      do_update = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SEARCH: ;
         ST_UPDATE: do_update = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign req_take = req_valid && req_ready;

   // ---- inject the search token at the head of the chain ----
   always_comb begin
      chain[0]             = '0;
      chain[0].valid       = req_take;
      chain[0].key         = req_sem_key;
   end

   for (genvar i = 0; i < SEM_ENTRIES; i++) begin : g_cell
      skla_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .left_token  (chain[i]),
         .right_token (chain[i+1]),
         .wr_cmd      (wr_cmd)
      );
   end

   // ---- decide from the finished token ----
   always_comb begin
      created    = !result_ff.match_found && result_ff.free_found;
      full       = !result_ff.match_found && !result_ff.free_found;
      sel_idx    = result_ff.match_found ? result_ff.match_idx : result_ff.free_idx;
      base_users = result_ff.match_found ? result_ff.match_users : '0;
      // saturate the user count at the process count
      new_users  = (int'(base_users) < PROCESSES) ? CNT_W'(base_users + 1'b1)
                                                  : base_users;
   end

   // broadcast the write-back; a full table changes nothing
   always_comb begin
      wr_cmd.valid   = do_update && !full;
      wr_cmd.create  = created;
      wr_cmd.idx     = sel_idx;
      wr_cmd.key     = result_ff.key;
      wr_cmd.users   = new_users;
      wr_cmd.proc_ok = int'(proc_ff) < PROCESSES;
      wr_cmd.proc    = proc_ff;
   end

   // hold the response until taken
   assign rsp_valid_in = do_update | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         proc_ff <= req_process_index;
      end
      if (chain[SEM_ENTRIES].valid) begin
         result_ff <= chain[SEM_ENTRIES];
      end
      if (do_update) begin
         rsp_id_ff      <= full ? '0 : ID_W'(sel_idx);
         rsp_full_ff    <= full;
         rsp_created_ff <= created;
         rsp_count_ff   <= full ? '0 : COUNT_W'(new_users);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_semaphore_id  = rsp_id_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_newly_created = rsp_created_ff;
   assign rsp_user_count    = rsp_count_ff;

endmodule

### src/skla_checker.sv
module skla_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [skla_pkg::ID_W-1:0]         rsp_semaphore_id,
   input logic                              rsp_table_full,
   input logic                              rsp_newly_created,
   input logic [skla_pkg::COUNT_W-1:0]      rsp_user_count
);
   import skla_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_semaphore_id) &&
      $stable(rsp_table_full) && $stable(rsp_newly_created) && $stable(rsp_user_count))
      else $error("response changed while stalled");

   // a failed request reports nothing else
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |->
      !rsp_newly_created && rsp_semaphore_id == '0 && rsp_user_count == '0)
      else $error("table-full response carries data");

   // success always leaves a count between one and the process count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_table_full |->
      rsp_user_count != '0 && int'(rsp_user_count) <= PROCESSES)
      else $error("user count out of range");

   // a fresh entry has exactly one user
   a_new_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_created |-> rsp_user_count == COUNT_W'(1))
      else $error("new entry count is not one");

   // no request taken while a search is in flight after acceptance
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during search");

endmodule

bind semaphore_key_lookup_or_allocate_unit skla_checker u_skla_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_semaphore_id  (rsp_semaphore_id),
   .rsp_table_full    (rsp_table_full),
   .rsp_newly_created (rsp_newly_created),
   .rsp_user_count    (rsp_user_count)
);
